/* sv/chbc_pkg.sv */
package chbc_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned PcW     = 64;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned CountW  = 8;

  localparam logic [63:0] MIX_MULT    = 64'hff51afd7ed558ccd;
  localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
  localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];
  localparam int unsigned MixShiftA   = 33;
  localparam int unsigned MixShiftB   = 29;

  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

endpackage

/* sv/coverage_hash_bucket_counter.sv */
// Channel   Handshake            Ports
// command   start, busy          cmd_i, pc_word_i, read_index_i
// result    done_o (strobe)      bucket_o, hit_count_o, saturated_o
//
// Record: the mix runs three 32x32 products on one shared multiplier, then the
//   modulo reduction takes the four 16-bit digits in turn, each by multiply,
//   subtract and fix-up, then one read and one write of the counter RAM.
// Read: busy while the RAM read is pending. Unused code: not busy, result next cycle.
// Clear: busy while every RAM word is zeroed, one RAM word per cycle.
// After reset the block sweeps the RAM to zero with busy high.
// done_o pulses for one cycle; the receiver cannot stall it.
module coverage_hash_bucket_counter #(
  parameter int unsigned NUM_BUCKETS = 4000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [chbc_pkg::CmdW-1:0]       cmd_i,
  input  logic [chbc_pkg::PcW-1:0]        pc_word_i,
  input  logic [chbc_pkg::IndexW-1:0]     read_index_i,
  output logic                            done_o,
  output logic [chbc_pkg::IndexW-1:0]     bucket_o,
  output logic [chbc_pkg::CountW-1:0]     hit_count_o,
  output logic                            saturated_o
);
  import chbc_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BUCKETS);
  localparam int unsigned IW = ((AW > IndexW) ? AW : IndexW) + 1;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_HASH  = 6'b001000,
    S_UPD   = 6'b010000,
    S_READ  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         b_q, b_d;
  logic [IndexW-1:0]     idx_q, idx_d;
  logic                  inr_q, inr_d;

  logic                  done_q, done_d;
  logic [IndexW-1:0]     bucket_q, bucket_d;
  logic [CountW-1:0]     count_q, count_d;
  logic                  sat_q, sat_d;

  logic [CountW-1:0]     counters_q [NUM_BUCKETS];
  logic [CountW-1:0]     rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [CountW-1:0]     mem_wdata;

  logic                  hash_start, hash_done;
  logic [AW-1:0]         hash_bucket;
  logic [IW-1:0]         idx_w;
  logic [IW-1:0]         b_w;
  logic                  accept;
  logic                  hit_max;
  cmd_e                  cmd;

  assign cmd        = cmd_e'(cmd_i);
  assign accept     = start && (state_q == S_IDLE);
  assign hash_start = accept && (cmd == CMD_RECORD);
  assign idx_w      = IW'(read_index_i);
  assign b_w        = IW'(b_q);
  assign hit_max    = (rdata_q == COUNT_MAX);

  chbc_hash #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .pc_word_i(pc_word_i),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    b_d       = b_q;
    idx_d     = idx_q;
    inr_d     = inr_q;
    done_d    = 1'b0;
    bucket_d  = '0;
    count_d   = '0;
    sat_d     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_w[AW-1:0];
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (ptr_q == AW'(NUM_BUCKETS - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
          done_d  = (state_q == S_CLEAR);
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_RECORD: begin
              state_d = S_HASH;
            end
            CMD_READ: begin
              mem_re  = 1'b1;
              idx_d   = read_index_i;
              inr_d   = (idx_w < IW'(NUM_BUCKETS));
              state_d = S_READ;
            end
            CMD_NONE: begin
              done_d = 1'b1;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          mem_re    = 1'b1;
          mem_raddr = hash_bucket;
          b_d       = hash_bucket;
          state_d   = S_UPD;
        end
      end
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = b_q;
        mem_wdata = hit_max ? rdata_q : rdata_q + CountW'(1);
        done_d    = 1'b1;
        bucket_d  = b_w[IndexW-1:0];
        count_d   = mem_wdata;
        sat_d     = hit_max;
        state_d   = S_IDLE;
      end
      S_READ: begin
        done_d   = 1'b1;
        bucket_d = idx_q;
        count_d  = inr_q ? rdata_q : '0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    idx_q <= idx_d;
    inr_q <= inr_d;
    if (done_d) begin
      bucket_q <= bucket_d;
      count_q  <= count_d;
      sat_q    <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      counters_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= counters_q[mem_raddr];
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign bucket_o    = bucket_q;
  assign hit_count_o = count_q;
  assign saturated_o = sat_q;

endmodule

/* sv/chbc_hash.sv */
module chbc_hash #(
  parameter int unsigned NUM_BUCKETS = 4000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [chbc_pkg::PcW-1:0]           pc_word_i,
  output logic                               done_o,
  output logic [$clog2(NUM_BUCKETS)-1:0]     bucket_o
);
  import chbc_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BUCKETS);
  localparam int unsigned RW = AW + 1;
  localparam logic [RW-1:0] NUM_R = RW'(NUM_BUCKETS);
  localparam int unsigned DigitW = 16;
  localparam int unsigned ModSteps = PcW / DigitW;
  localparam int unsigned SW = $clog2(ModSteps);
  localparam logic [31:0] Recip = 32'(64'h1_0000_0000 / 64'(NUM_BUCKETS));
  localparam logic [31:0] NumQ = 32'(NUM_BUCKETS);

  typedef enum logic [8:0] {
    H_IDLE = 9'b000000001,
    H_MLO  = 9'b000000010,
    H_MX1  = 9'b000000100,
    H_MX2  = 9'b000001000,
    H_SUM  = 9'b000010000,
    H_DMUL = 9'b000100000,
    H_DSUB = 9'b001000000,
    H_DFIX = 9'b010000000,
    H_DONE = 9'b100000000
  } hstate_e;

  hstate_e            state_q, state_d;
  logic [PcW-1:0]     x_q, x_d;
  logic [63:0]        p_q, p_d;
  logic [31:0]        c_q, c_d;
  logic [AW-1:0]      r_q, r_d;
  logic [SW-1:0]      step_q, step_d;
  logic [DigitW-1:0]  q_q, q_d;
  logic [RW-1:0]      e_q, e_d;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic [63:0]    h_sum;
  logic [RW-1:0]  t;
  logic [31:0]    dig_v;
  logic [31:0]    qn;
  logic [31:0]    rem_w;

  // remainder taken one 16-bit digit at a time; the quotient estimate is low by at most one
  assign dig_v = {DigitW'(r_q), x_q[PcW-1 -: DigitW]};
  assign mul_a = (state_q == H_MX1)  ? x_q[63:32] :
                 (state_q == H_DMUL) ? dig_v : x_q[31:0];
  assign mul_b = (state_q == H_MX2)  ? MIX_MULT_HI :
                 (state_q == H_DMUL) ? Recip : MIX_MULT_LO;
  assign prod  = mul_a * mul_b;
  assign h_sum = p_q + {c_q, 32'd0};
  assign qn    = 32'(q_q) * NumQ;
  assign rem_w = dig_v - qn;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    p_d     = p_q;
    c_d     = c_q;
    r_d     = r_q;
    step_d  = step_q;
    q_d     = q_q;
    e_d     = e_q;
    t       = '0;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          x_d     = pc_word_i ^ (pc_word_i >> MixShiftA);
          state_d = H_MLO;
        end
      end
      H_MLO: begin
        p_d     = prod;
        state_d = H_MX1;
      end
      H_MX1: begin
        c_d     = prod[31:0];
        state_d = H_MX2;
      end
      H_MX2: begin
        c_d     = c_q + prod[31:0];
        state_d = H_SUM;
      end
      H_SUM: begin
        x_d     = h_sum ^ (h_sum >> MixShiftB);
        r_d     = '0;
        step_d  = '0;
        state_d = H_DMUL;
      end
      H_DMUL: begin
        q_d     = prod[32 +: DigitW];
        state_d = H_DSUB;
      end
      H_DSUB: begin
        e_d     = rem_w[RW-1:0];
        state_d = H_DFIX;
      end
      H_DFIX: begin
        t      = (e_q >= NUM_R) ? e_q - NUM_R : e_q;
        r_d    = t[AW-1:0];
        x_d    = x_q << DigitW;
        step_d = step_q + SW'(1);
        if (step_q == SW'(ModSteps - 1)) begin
          state_d = H_DONE;
        end else begin
          state_d = H_DMUL;
        end
      end
      H_DONE: begin
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    p_q <= p_d;
    c_q <= c_d;
    r_q <= r_d;
    q_q <= q_d;
    e_q <= e_d;
  end

  assign done_o   = (state_q == H_DONE);
  assign bucket_o = r_q;

endmodule

/* sv/chbc_checker.sv */
module chbc_assertions (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [chbc_pkg::CmdW-1:0]       cmd_i,
  input logic                            done_o,
  input logic [chbc_pkg::IndexW-1:0]     bucket_o,
  input logic [chbc_pkg::CountW-1:0]     hit_count_o,
  input logic                            saturated_o
);
  import chbc_pkg::*;

  logic acc;
  assign acc = start && !busy;

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> hit_count_o == COUNT_MAX)
    else $error("saturated result without full count");

  a_busy_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd_i == CMD_CLEAR || cmd_i == CMD_RECORD || cmd_i == CMD_READ) |=> busy)
    else $error("block idle after accepting a working transaction");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd_i == CMD_READ |=> ##1 (done_o && !saturated_o))
    else $error("read transaction result missing or marked saturated");

  a_none_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd_i == CMD_NONE |=>
      (done_o && bucket_o == '0 && hit_count_o == '0 && !saturated_o))
    else $error("unused command did not return an empty result");

endmodule

bind coverage_hash_bucket_counter chbc_assertions u_chbc_assertions (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .cmd_i      (cmd_i),
  .done_o     (done_o),
  .bucket_o   (bucket_o),
  .hit_count_o(hit_count_o),
  .saturated_o(saturated_o)
);

/* bench/chbc_checker.sv */
module chbc_checker
  import chbc_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 4000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [PcW-1:0]       pc_word_i,
  input  logic [IndexW-1:0]    read_index_i,
  input  logic                 done_o,
  input  logic [IndexW-1:0]    bucket_o,
  input  logic [CountW-1:0]    hit_count_o,
  input  logic                 saturated_o,
  output int unsigned          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0]       HashMult  = 64'hff51afd7ed558ccd;
  localparam int unsigned       HashShA   = 33;
  localparam int unsigned       HashShB   = 29;
  localparam logic [CountW-1:0] CountTop  = 8'd255;

  typedef struct packed {
    logic [IndexW-1:0] bucket;
    logic [CountW-1:0] count;
    logic              sat;
  } tally_t;

  logic [CountW-1:0] hit_counts [NUM_BUCKETS];
  tally_t            expected_q [$];

  function automatic logic [IndexW-1:0] hash_bucket(logic [PcW-1:0] pc);
    logic [63:0] x;
    x = pc ^ (pc >> HashShA);
    x = x * HashMult;
    x = x ^ (x >> HashShB);
    return IndexW'(x % 64'(NUM_BUCKETS));
  endfunction

  function automatic tally_t apply_command(cmd_e op, logic [PcW-1:0] pc,
                                           logic [IndexW-1:0] idx);
    tally_t t;
    logic [IndexW-1:0] b;
    t = '0;
    case (op)
      CMD_CLEAR: begin
        foreach (hit_counts[i]) hit_counts[i] = '0;
      end
      CMD_RECORD: begin
        b = hash_bucket(pc);
        if (hit_counts[b] == CountTop) begin
          t.sat = 1'b1;
        end else begin
          hit_counts[b] = hit_counts[b] + 1'b1;
        end
        t.bucket = b;
        t.count  = hit_counts[b];
      end
      CMD_READ: begin
        t.bucket = idx;
        if (idx < NUM_BUCKETS) t.count = hit_counts[idx];
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tally_t want;
    tally_t got;
    if (!rst_ni) begin
      foreach (hit_counts[i]) hit_counts[i] = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(apply_command(cmd_e'(cmd_i), pc_word_i, read_index_i));
      end
      if (done_o) begin
        got = '{bucket_o, hit_count_o, saturated_o};
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result bucket=%0d count=%0d sat=%0b",
                     $realtime, got.bucket, got.count, got.sat);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp bucket=%0d count=%0d sat=%0b, got bucket=%0d count=%0d sat=%0b",
                       $realtime, want.bucket, want.count, want.sat,
                       got.bucket, got.count, got.sat);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* bench/tb_top.sv */
module tb_top
  import chbc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBuckets = 4000;
  localparam int unsigned ItemTarget = 1600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [CmdW-1:0]      cmd_i;
  logic [PcW-1:0]       pc_word_i;
  logic [IndexW-1:0]    read_index_i;
  logic                 done_o;
  logic [IndexW-1:0]    bucket_o;
  logic [CountW-1:0]    hit_count_o;
  logic                 saturated_o;
  int unsigned          fail_count;

  int unsigned          items_sent;
  int unsigned          results_seen;
  int unsigned          real_items;
  logic [IndexW-1:0]    recent_bucket;
  logic [PcW-1:0]       pc_pool [8];
  bit                   no_idle;

  coverage_hash_bucket_counter #(.NUM_BUCKETS(NumBuckets)) dut (.*);

  chbc_checker #(.NUM_BUCKETS(NumBuckets)) u_checker (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (done_o) results_seen <= results_seen + 1;
    if (done_o && hit_count_o != '0) recent_bucket <= bucket_o;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PcW-1:0] rand_pc();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IndexW-1:0] rand_idx();
    return IndexW'($urandom_range(0, (1 << IndexW) - 1));
  endfunction

  task automatic send(cmd_e op, logic [PcW-1:0] pc, logic [IndexW-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= op;
    pc_word_i    <= pc;
    read_index_i <= idx;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (op != CMD_NONE) real_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (results_seen != items_sent);
  endtask

  task automatic mixed_run(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 30) send(CMD_RECORD, rand_pc(), rand_idx());
      else if (r < 58) send(CMD_RECORD, pc_pool[$urandom_range(0, 7)], rand_idx());
      else if (r < 76) send(CMD_READ, rand_pc(), recent_bucket);
      else if (r < 94) send(CMD_READ, rand_pc(), rand_idx());
      else send(CMD_NONE, rand_pc(), rand_idx());
    end
  endtask

  // hammer one PC past saturation, with reads of its bucket mixed in
  task automatic hot_burst();
    logic [PcW-1:0] pc;
    int unsigned    n;
    pc = rand_pc();
    n  = $urandom_range(256, 300);
    while (n > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send(CMD_READ, rand_pc(), recent_bucket);
      end else begin
        send(CMD_RECORD, pc, rand_idx());
        n--;
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    cmd_i        <= CMD_CLEAR;
    pc_word_i    <= '0;
    read_index_i <= '0;
    items_sent   = 0;
    results_seen = 0;
    real_items   = 0;
    recent_bucket = '0;
    no_idle      = 1'b0;
    foreach (pc_pool[i]) pc_pool[i] = rand_pc();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(CMD_READ,   '0, '0);
    send(CMD_READ,   '1, 12'(NumBuckets - 1));
    send(CMD_READ,   '0, 12'(NumBuckets));
    send(CMD_READ,   '0, '1);
    send(CMD_RECORD, '0, '0);
    send(CMD_RECORD, '0, '1);
    send(CMD_RECORD, '1, '0);
    send(CMD_RECORD, 64'h8000_0000_0000_0000, '0);
    send(CMD_RECORD, 64'h0000_0001_0000_0000, '0);
    send(CMD_RECORD, 64'h0000_0000_0000_0001, '0);
    send(CMD_RECORD, '1, '1);
    drain();
    send(CMD_READ,   '0, recent_bucket);
    send(CMD_NONE,   '1, '1);
    send(CMD_NONE,   '0, '0);
    send(CMD_CLEAR,  '1, '1);
    send(CMD_READ,   '1, recent_bucket);
    send(CMD_RECORD, 64'hdead_beef_cafe_f00d, '0);
    send(CMD_RECORD, 64'hdead_beef_cafe_f00d, '0);
    send(CMD_CLEAR,  '0, '0);
    send(CMD_RECORD, 64'hdead_beef_cafe_f00d, '0);
    drain();

    real_items = 0;
    while (real_items < ItemTarget) begin : episodes
      int unsigned r;
      r = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 9) < 3);
      if (r < 8) begin
        hot_burst();
      end else if (r < 12) begin
        send(CMD_CLEAR, rand_pc(), rand_idx());
      end else if (r < 16) begin
        drain();
      end else begin
        if ($urandom_range(0, 3) == 0) pc_pool[$urandom_range(0, 7)] = rand_pc();
        mixed_run($urandom_range(20, 60));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
